// ----- rtl/core/multi_sensor_echo_averager_assert.svh -----
// Assertion macros shared by the echo averager RTL.
// Each expects clk_i and rst_ni in the scope of the including module.
`ifndef MULTI_SENSOR_ECHO_AVERAGER_ASSERT_SVH
`define MULTI_SENSOR_ECHO_AVERAGER_ASSERT_SVH

// Plain property that must hold at every clock edge out of reset
`define MSEA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define MSEA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSEA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/msea_pkg.sv -----
// Shared constants, types and helper functions of the echo averager.
// Used by every module in rtl/core; depends on nothing.
package msea_pkg;

  // Block dimensions
  localparam int SENSORS  = 4;
  localparam int WINDOW   = 40;
  localparam int CALC_DIV = 7;

  // Field and state widths
  localparam int SIDX_W    = 2;
  localparam int CNT_W     = 16;
  localparam int DIST_W    = 14;
  localparam int MASK_W    = 4;
  localparam int SUM_W     = 22;
  localparam int FCNT_W    = 8;
  localparam int SCNT_W    = 3;
  localparam int THR_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PTR_W     = $clog2(WINDOW);
  localparam int ADDR_W    = $clog2(SENSORS * WINDOW);

  // Divide by WINDOW*CALC_DIV as multiply by reciprocal, exact for any sum below 2**SUM_W
  localparam int          DIV_DEN    = WINDOW * CALC_DIV;
  localparam int          DIV_SHIFT  = 32;
  localparam int          DIV_MULT_W = 32;
  localparam logic [63:0] DIV_MULT   = ((64'd1 << DIV_SHIFT) + 64'(DIV_DEN) - 64'd1)
                                       / 64'(DIV_DEN);
  localparam int          PROD_W     = SUM_W + DIV_MULT_W;

  localparam logic [FCNT_W-1:0] FCNT_MAX = '1;

  // Configuration register reset values
  localparam logic [SCNT_W-1:0] RST_SENSOR_COUNT = SCNT_W'(4);
  localparam logic [THR_W-1:0]  RST_FAULT_THR    = THR_W'(10);
  localparam logic [CNT_W-1:0]  RST_OVER_LIMIT   = CNT_W'(51200);
  localparam logic [CNT_W-1:0]  RST_NO_OBS_LIMIT = CNT_W'(32000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_OBS_LIMIT = 2'd3;

  // Event codes
  typedef enum logic [1:0] {
    MODE_ECHO    = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_CHECK   = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [SCNT_W-1:0] sensor_count;
    logic [THR_W-1:0]  fault_threshold;
    logic [CNT_W-1:0]  over_limit;
    logic [CNT_W-1:0]  no_obstacle_limit;
  } cfg_t;

  // One event as it travels down the pipeline
  typedef struct packed {
    mode_e             mode;
    logic [CNT_W-1:0]  cnt;
    logic [SIDX_W-1:0] sensor;
    logic              store;    // count goes into the ring
    logic              fault;    // count as a failed reading
    logic              lap_hit;  // ring entry read back holds a real sample
    logic [ADDR_W-1:0] addr;     // ring entry of this sample
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Clamp the sensor count to 1..SENSORS
  function automatic logic [SCNT_W-1:0] active_count(logic [SCNT_W-1:0] sc);
    logic [SCNT_W-1:0] n;
    n = sc;
    if (sc == '0) begin
      n = SCNT_W'(1);
    end else if (sc > SCNT_W'(SENSORS)) begin
      n = SCNT_W'(SENSORS);
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/msea_ring_ram.sv -----
// Echo sample ring storage: one write port, one registered read port.
// Depends on msea_pkg for depth and widths.
module msea_ring_ram (
  input  logic                       clk_i,
  input  msea_pkg::ram_req_t         req_i,
  output logic [msea_pkg::CNT_W-1:0] rd_data_o
);

  logic [msea_pkg::CNT_W-1:0] mem [msea_pkg::SENSORS * msea_pkg::WINDOW];
  logic [msea_pkg::CNT_W-1:0] rd_data_q;

  // Write and read; read data is registered and valid in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/msea_front.sv -----
// Event intake: round-robin rotation, ring pointers and ring read issue.
// Depends on msea_pkg and the assertion macro header.
`include "multi_sensor_echo_averager_assert.svh"

module msea_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msea_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   mode_i,
  input  logic [msea_pkg::CNT_W-1:0]   echo_count_i,
  output msea_pkg::item_t              item_o,
  output logic                         rd_en_o,
  output logic [msea_pkg::ADDR_W-1:0]  rd_addr_o
);

  logic [msea_pkg::SIDX_W-1:0] cur_q, cur_d;
  logic [msea_pkg::PTR_W-1:0]  ptr_q [msea_pkg::SENSORS];
  logic [msea_pkg::SENSORS-1:0] lap_q;

  msea_pkg::mode_e             mode;
  logic                        accept;
  logic                        is_over, is_no_obs;
  logic                        store, advance;
  logic [msea_pkg::PTR_W:0]    ptr_inc;
  logic [msea_pkg::PTR_W-1:0]  ptr_next;
  logic [msea_pkg::SCNT_W-1:0] n_active, cur_inc;
  logic [msea_pkg::ADDR_W-1:0] addr;

  // Classify the event and find its ring entry
  always_comb begin
    mode      = msea_pkg::mode_e'(mode_i);
    accept    = in_valid_i && in_ready_i;
    is_over   = echo_count_i > cfg_i.over_limit;
    is_no_obs = echo_count_i > cfg_i.no_obstacle_limit;
    store     = (mode == msea_pkg::MODE_ECHO) && !is_over && !is_no_obs;
    advance   = (mode == msea_pkg::MODE_ECHO) || (mode == msea_pkg::MODE_TIMEOUT);

    ptr_inc  = {1'b0, ptr_q[cur_q]} + (msea_pkg::PTR_W + 1)'(1);
    ptr_next = (ptr_inc >= (msea_pkg::PTR_W + 1)'(msea_pkg::WINDOW)) ? '0
               : ptr_inc[msea_pkg::PTR_W-1:0];
    addr     = msea_pkg::ADDR_W'(32'(cur_q) * msea_pkg::WINDOW + 32'(ptr_next));

    n_active = msea_pkg::active_count(cfg_i.sensor_count);
    cur_inc  = msea_pkg::SCNT_W'(cur_q) + msea_pkg::SCNT_W'(1);
    cur_d    = (cur_inc >= n_active) ? '0 : cur_inc[msea_pkg::SIDX_W-1:0];

    item_o.mode    = mode;
    item_o.cnt     = echo_count_i;
    item_o.sensor  = cur_q;
    item_o.store   = store;
    item_o.fault   = (mode == msea_pkg::MODE_TIMEOUT) ||
                     ((mode == msea_pkg::MODE_ECHO) && is_over);
    item_o.lap_hit = lap_q[cur_q];
    item_o.addr    = addr;
  end

  assign rd_en_o   = accept;
  assign rd_addr_o = addr;

  // On each accepted transaction, advance rotation (echo or timeout) and ring pointer (stored sample)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      lap_q <= '0;
      for (int i = 0; i < msea_pkg::SENSORS; i++) begin
        ptr_q[i] <= '0;
      end
    end else if (accept) begin
      if (advance) begin
        cur_q <= cur_d;
      end
      if (store) begin
        ptr_q[cur_q] <= ptr_next;
        // Entry zero is the last one filled on the first lap
        if (ptr_next == '0) begin
          lap_q[cur_q] <= 1'b1;
        end
      end
    end
  end

  `MSEA_ASSERT(a_ptr_in_window, ptr_q[cur_q] < msea_pkg::PTR_W'(msea_pkg::WINDOW), "ring pointer out of window")
  `MSEA_ASSERT_NEXT(a_lap_sticks, accept && store && (ptr_next == '0), lap_q[$past(cur_q)], "lap flag not set after wrap")

endmodule

// ----- rtl/core/msea_update.sv -----
// Update pipeline: running sum, reciprocal divide, flags, fault mask, result.
// Depends on msea_pkg and the assertion macro header.
`include "multi_sensor_echo_averager_assert.svh"

module msea_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msea_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  msea_pkg::item_t               item_i,
  input  logic [msea_pkg::CNT_W-1:0]    rd_data_i,
  output logic                          wr_en_o,
  output logic [msea_pkg::ADDR_W-1:0]   wr_addr_o,
  output logic [msea_pkg::CNT_W-1:0]    wr_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msea_pkg::SIDX_W-1:0]   sensor_index_o,
  output logic [msea_pkg::DIST_W-1:0]   distance_mm_o,
  output logic                          reading_ok_o,
  output logic [msea_pkg::MASK_W-1:0]   fault_mask_o
);

  // Stage registers: a = ring read pending, b = new sum, c = product
  logic                        va_q, vb_q, vc_q, vo_q;
  msea_pkg::item_t             a_item_q, b_item_q, c_item_q;
  logic [msea_pkg::SUM_W-1:0]  b_sum_q;
  logic [msea_pkg::PROD_W-1:0] c_prod_q;
  logic                        en_a, en_b, en_c, en_o;

  // Per-sensor state
  logic [msea_pkg::SUM_W-1:0]  sum_q  [msea_pkg::SENSORS];
  logic [msea_pkg::DIST_W-1:0] dist_q [msea_pkg::SENSORS];
  logic [msea_pkg::DIST_W-1:0] dist_d [msea_pkg::SENSORS];
  logic [msea_pkg::FCNT_W-1:0] fcnt_q [msea_pkg::SENSORS];
  logic [msea_pkg::FCNT_W-1:0] fcnt_d [msea_pkg::SENSORS];
  logic [msea_pkg::SENSORS-1:0] ok_q, ok_d;
  logic [msea_pkg::MASK_W-1:0]  mask_q, mask_d;

  // Output register
  logic [msea_pkg::SIDX_W-1:0] out_sensor_q;
  logic [msea_pkg::DIST_W-1:0] out_dist_q;
  logic                        out_ok_q;

  logic [msea_pkg::CNT_W-1:0]  old_sample;
  logic [msea_pkg::SUM_W-1:0]  sum_new;
  logic [msea_pkg::PROD_W-1:0] prod;
  logic [msea_pkg::DIST_W-1:0] dist_new;
  logic [msea_pkg::SCNT_W-1:0] n_active;
  logic [msea_pkg::SIDX_W-1:0] cs;
  logic                        fin;

  // Each stage loads when it is empty or its successor moves
  assign en_o       = !vo_q || out_ready_i;
  assign en_c       = !vc_q || en_o;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // Replace the oldest sample in the running sum; write the new one back
  always_comb begin
    old_sample = a_item_q.lap_hit ? rd_data_i : '0;
    sum_new    = sum_q[a_item_q.sensor] - msea_pkg::SUM_W'(old_sample)
                 + msea_pkg::SUM_W'(a_item_q.cnt);
    wr_en_o    = va_q && en_b && a_item_q.store;
    wr_addr_o  = a_item_q.addr;
    wr_data_o  = a_item_q.cnt;
  end

  // Multiply by the reciprocal of WINDOW*CALC_DIV
  assign prod = {{msea_pkg::DIV_MULT_W{1'b0}}, b_sum_q}
              * {{msea_pkg::SUM_W{1'b0}}, msea_pkg::DIV_MULT[msea_pkg::DIV_MULT_W-1:0]};
  assign dist_new = c_prod_q[msea_pkg::DIV_SHIFT +: msea_pkg::DIST_W];

  // Apply the event to flags, fault counts and mask
  always_comb begin
    cs       = c_item_q.sensor;
    fin      = vc_q && en_o;
    n_active = msea_pkg::active_count(cfg_i.sensor_count);
    dist_d   = dist_q;
    fcnt_d   = fcnt_q;
    ok_d     = ok_q;
    mask_d   = mask_q;
    if (c_item_q.store) begin
      dist_d[cs] = dist_new;
      ok_d[cs]   = 1'b1;
    end
    if (c_item_q.fault) begin
      if (fcnt_q[cs] != msea_pkg::FCNT_MAX) begin
        fcnt_d[cs] = fcnt_q[cs] + msea_pkg::FCNT_W'(1);
      end
      ok_d[cs] = 1'b0;
    end
    if (c_item_q.mode == msea_pkg::MODE_CHECK) begin
      for (int i = 0; i < msea_pkg::SENSORS; i++) begin
        if (msea_pkg::SCNT_W'(i) < n_active) begin
          if (!ok_q[i]) begin
            if (fcnt_q[i] > cfg_i.fault_threshold) begin
              mask_d[i] = 1'b1;
            end
          end else begin
            fcnt_d[i] = '0;
          end
        end
      end
    end
    if (c_item_q.mode == msea_pkg::MODE_CLEAR) begin
      mask_d = '0;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_o) vo_q <= vc_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_item_q <= item_i;
    end
    if (en_b && va_q) begin
      b_item_q <= a_item_q;
      b_sum_q  <= sum_new;
    end
    if (en_c && vb_q) begin
      c_item_q <= b_item_q;
      c_prod_q <= prod;
    end
    if (fin) begin
      out_sensor_q <= cs;
      out_dist_q   <= dist_d[cs];
      out_ok_q     <= ok_d[cs];
    end
  end

  // Sensor state, updated in event order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= '0;
      mask_q <= '0;
      for (int i = 0; i < msea_pkg::SENSORS; i++) begin
        sum_q[i]  <= '0;
        dist_q[i] <= '0;
        fcnt_q[i] <= '0;
      end
    end else begin
      if (va_q && en_b && a_item_q.store) begin
        sum_q[a_item_q.sensor] <= sum_new;
      end
      if (fin) begin
        dist_q <= dist_d;
        fcnt_q <= fcnt_d;
        ok_q   <= ok_d;
        mask_q <= mask_d;
      end
    end
  end

  assign out_valid_o    = vo_q;
  assign sensor_index_o = out_sensor_q;
  assign distance_mm_o  = out_dist_q;
  assign reading_ok_o   = out_ok_q;
  assign fault_mask_o   = mask_q;

  `MSEA_ASSERT_IMP(a_out_from_pipe, $rose(out_valid_o), $past(vc_q), "result without pipeline item")
  `MSEA_ASSERT_NEXT(a_store_sets_ok, fin && c_item_q.store, reading_ok_o, "stored reading not flagged ok")
  `MSEA_ASSERT_NEXT(a_clear_empties, fin && (c_item_q.mode == msea_pkg::MODE_CLEAR), fault_mask_o == '0, "fault mask not cleared")

endmodule

// ----- rtl/core/multi_sensor_echo_averager.sv -----
// Top level of the multi-sensor echo averager: configuration registers,
// event intake, ring memory and update pipeline. Depends on msea_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+----------------------------------------------
//  config   | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//  event in | in_valid_i/in_ready_o  | mode_i, echo_count_i
//  result   | out_valid_o/out_ready_i| sensor_index_o, distance_mm_o, reading_ok_o,
//           |                        | fault_mask_o
//
// One event per cycle sustained unless the output stalls. Each result passes four
// register stages: ring read latency, sum update, reciprocal multiply and output
// register. Ring contents read as zero after reset through per-sensor lap flags,
// so no clearing pass is needed. A stalled output holds the pipeline stage by stage;
// empty stages still take events.
`include "multi_sensor_echo_averager_assert.svh"

module multi_sensor_echo_averager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [msea_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic [msea_pkg::CNT_W-1:0]     echo_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [msea_pkg::SIDX_W-1:0]    sensor_index_o,
  output logic [msea_pkg::DIST_W-1:0]    distance_mm_o,
  output logic                           reading_ok_o,
  output logic [msea_pkg::MASK_W-1:0]    fault_mask_o
);

  msea_pkg::cfg_t             cfg_q;
  msea_pkg::item_t            item;
  msea_pkg::ram_req_t         ram_req;
  logic [msea_pkg::CNT_W-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_count      <= msea_pkg::RST_SENSOR_COUNT;
      cfg_q.fault_threshold   <= msea_pkg::RST_FAULT_THR;
      cfg_q.over_limit        <= msea_pkg::RST_OVER_LIMIT;
      cfg_q.no_obstacle_limit <= msea_pkg::RST_NO_OBS_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msea_pkg::REG_SENSOR_COUNT:
          cfg_q.sensor_count <= cfg_wdata_i[msea_pkg::SCNT_W-1:0];
        msea_pkg::REG_FAULT_THR:
          cfg_q.fault_threshold <= cfg_wdata_i[msea_pkg::THR_W-1:0];
        msea_pkg::REG_OVER_LIMIT:
          cfg_q.over_limit <= cfg_wdata_i[msea_pkg::CNT_W-1:0];
        msea_pkg::REG_NO_OBS_LIMIT:
          cfg_q.no_obstacle_limit <= cfg_wdata_i[msea_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  msea_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .echo_count_i (echo_count_i),
    .item_o       (item),
    .rd_en_o      (ram_req.re),
    .rd_addr_o    (ram_req.raddr)
  );

  msea_ring_ram u_ring (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  msea_update u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .item_i         (item),
    .rd_data_i      (rd_data),
    .wr_en_o        (ram_req.we),
    .wr_addr_o      (ram_req.waddr),
    .wr_data_o      (ram_req.wdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sensor_index_o (sensor_index_o),
    .distance_mm_o  (distance_mm_o),
    .reading_ok_o   (reading_ok_o),
    .fault_mask_o   (fault_mask_o)
  );

  `MSEA_ASSERT_IMP(a_ring_no_collide, ram_req.we && ram_req.re,
                   ram_req.waddr != ram_req.raddr, "ring read and write hit the same entry")

endmodule

// ----- tb/multi_sensor_echo_averager_tb.sv -----
// Self-checking testbench for multi_sensor_echo_averager: directed and random
// event streams, checked against a scoreboard that tracks per-sensor echo state.
// Depends on msea_pkg and the multi_sensor_echo_averager RTL.
`timescale 1ns / 100ps

module multi_sensor_echo_averager_tb;
  import msea_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct {
    logic [SIDX_W-1:0] sensor;
    logic [DIST_W-1:0] distance;
    logic              ok;
    logic [MASK_W-1:0] mask;
  } reading_t;

  // Tracks sensor state and the readings the block owes us
  class echo_avg_tracker;
    logic [SCNT_W-1:0] sensor_count;
    logic [THR_W-1:0]  fault_threshold;
    logic [CNT_W-1:0]  over_limit;
    logic [CNT_W-1:0]  no_obstacle_limit;

    bit [CNT_W-1:0]    ring [SENSORS*WINDOW];
    int unsigned       ring_pos [SENSORS];
    bit [SUM_W-1:0]    ring_sum [SENSORS];
    bit [DIST_W-1:0]   dist_mm [SENSORS];
    bit                ok_flag [SENSORS];
    bit [FCNT_W-1:0]   fail_count [SENSORS];
    bit [MASK_W-1:0]   fault_bits;
    int unsigned       cur_sensor;

    reading_t          expected_readings [$];
    int                errors;

    function new();
      sensor_count      = RST_SENSOR_COUNT;
      fault_threshold   = RST_FAULT_THR;
      over_limit        = RST_OVER_LIMIT;
      no_obstacle_limit = RST_NO_OBS_LIMIT;
      foreach (ring[k]) ring[k] = '0;
      for (int k = 0; k < SENSORS; k++) begin
        ring_pos[k]   = 0;
        ring_sum[k]   = '0;
        dist_mm[k]    = '0;
        ok_flag[k]    = 1'b0;
        fail_count[k] = '0;
      end
      fault_bits = '0;
      cur_sensor = 0;
      errors     = 0;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return expected_readings.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SENSOR_COUNT: sensor_count      = data[SCNT_W-1:0];
        REG_FAULT_THR:    fault_threshold   = data[THR_W-1:0];
        REG_OVER_LIMIT:   over_limit        = data[CNT_W-1:0];
        REG_NO_OBS_LIMIT: no_obstacle_limit = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_fault(int unsigned s);
      if (fail_count[s] != FCNT_MAX) fail_count[s]++;
      ok_flag[s] = 1'b0;
    endfunction

    // Update sensor state for one event and queue the reading it produces
    function void note_event(logic [1:0] mode_bits, logic [CNT_W-1:0] cnt);
      mode_e       m;
      int unsigned s;
      int unsigned p;
      int unsigned n;
      reading_t    r;
      m = mode_e'(mode_bits);
      s = cur_sensor % SENSORS;
      n = sensor_count;
      if (n < 1) n = 1;
      if (n > SENSORS) n = SENSORS;
      case (m)
        MODE_ECHO: begin
          if (cnt > over_limit) begin
            add_fault(s);
          end else if (cnt <= no_obstacle_limit) begin
            // Replace the oldest sample in the window and recompute
            p = ring_pos[s] + 1;
            if (p >= WINDOW) p = 0;
            ring_pos[s] = p;
            ring_sum[s] = ring_sum[s] - SUM_W'(ring[s*WINDOW+p]) + SUM_W'(cnt);
            ring[s*WINDOW+p] = cnt;
            dist_mm[s] = DIST_W'((ring_sum[s] / WINDOW) / CALC_DIV);
            ok_flag[s] = 1'b1;
          end
        end
        MODE_TIMEOUT: add_fault(s);
        MODE_CHECK: begin
          for (int i = 0; i < n; i++) begin
            if (!ok_flag[i]) begin
              if (fail_count[i] > fault_threshold) fault_bits[i] = 1'b1;
            end else begin
              fail_count[i] = '0;
            end
          end
        end
        default: fault_bits = '0;
      endcase
      // Advance the rotation on echo and timeout events only
      if (m == MODE_ECHO || m == MODE_TIMEOUT) begin
        cur_sensor = (cur_sensor + 1 >= n) ? 0 : cur_sensor + 1;
      end
      r.sensor   = SIDX_W'(s);
      r.distance = dist_mm[s];
      r.ok       = ok_flag[s];
      r.mask     = fault_bits;
      expected_readings.push_back(r);
    endfunction

    task check_result(logic [SIDX_W-1:0] sidx, logic [DIST_W-1:0] d,
                      logic ok, logic [MASK_W-1:0] mask);
      reading_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("unexpected result sensor=%0d dist=%0d ok=%0b mask=%h",
                         sidx, d, ok, mask));
        return;
      end
      want = expected_readings.pop_front();
      if (sidx !== want.sensor)
        report($sformatf("sensor_index got %0d want %0d", sidx, want.sensor));
      if (d !== want.distance)
        report($sformatf("distance_mm got %0d want %0d (sensor %0d)",
                         d, want.distance, want.sensor));
      if (ok !== want.ok)
        report($sformatf("reading_ok got %0b want %0b (sensor %0d)", ok, want.ok, want.sensor));
      if (mask !== want.mask)
        report($sformatf("fault_mask got %h want %h", mask, want.mask));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           mode_i;
  logic [CNT_W-1:0]     echo_count_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SIDX_W-1:0]    sensor_index_o;
  logic [DIST_W-1:0]    distance_mm_o;
  logic                 reading_ok_o;
  logic [MASK_W-1:0]    fault_mask_o;

  echo_avg_tracker sb;
  bit              send_gaps;
  bit              recv_gaps;
  bit              long_hold_req;
  int              hold_left;
  int              stall_cycles;

  multi_sensor_echo_averager dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .echo_count_i   (echo_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sensor_index_o (sensor_index_o),
    .distance_mm_o  (distance_mm_o),
    .reading_ok_o   (reading_ok_o),
    .fault_mask_o   (fault_mask_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Record every transaction on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_event(mode_i, echo_count_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(sensor_index_o, distance_mm_o, reading_ok_o, fault_mask_o);
    end
  end

  // End the run when no transaction happens for too long
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Drive result backpressure: short random stalls plus one long hold-off
  initial begin
    out_ready_i <= 1'b0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one event and hold it until the transaction; maybe idle afterwards
  task automatic send_event(mode_e m, logic [CNT_W-1:0] cnt);
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    echo_count_i <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every queued reading has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    // Let the monitor note the last transaction before counting
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Load all four registers while the block is idle
  task automatic apply_setting(logic [2:0] count, logic [7:0] thr, logic [15:0] over,
                               logic [15:0] no_obs);
    wait_drained();
    cfg_write(REG_SENSOR_COUNT, {13'($urandom), count});
    cfg_write(REG_FAULT_THR, {8'($urandom), thr});
    cfg_write(REG_OVER_LIMIT, over);
    cfg_write(REG_NO_OBS_LIMIT, no_obs);
    cfg_we_i <= 1'b0;
  endtask

  // Pick an echo count around the current limits or anywhere in range
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sb.over_limit;
      3:       return sb.over_limit + 16'd1;
      4:       return sb.no_obstacle_limit;
      5:       return sb.no_obstacle_limit + 16'd1;
      6, 7:    return CNT_W'($urandom_range(0, sb.no_obstacle_limit));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  task automatic run_random(int items, int w_echo, int w_timeout, int w_check, int w_clear);
    int    pick;
    mode_e m;
    repeat (items) begin
      pick = $urandom_range(0, w_echo + w_timeout + w_check + w_clear - 1);
      if (pick < w_echo) m = MODE_ECHO;
      else if (pick < w_echo + w_timeout) m = MODE_TIMEOUT;
      else if (pick < w_echo + w_timeout + w_check) m = MODE_CHECK;
      else m = MODE_CLEAR;
      send_event(m, pick_count());
    end
  endtask

  initial begin
    sb = new();
    send_gaps     = 1'b0;
    recv_gaps     = 1'b0;
    long_hold_req = 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_SENSOR_COUNT;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_ECHO;
    echo_count_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: both limits, their neighbors, and every event type
    send_event(MODE_ECHO, 16'd0);
    send_event(MODE_ECHO, 16'd32000);
    send_event(MODE_ECHO, 16'd32001);
    send_event(MODE_ECHO, 16'd51200);
    send_event(MODE_ECHO, 16'd51201);
    send_event(MODE_ECHO, 16'hFFFF);
    send_event(MODE_TIMEOUT, 16'd0);
    send_event(MODE_CHECK, 16'd0);
    send_event(MODE_CLEAR, 16'd0);

    // Single sensor, zero threshold and zero limits: mark, then clear, the mask
    apply_setting(3'd1, 8'd0, 16'd0, 16'd0);
    send_event(MODE_ECHO, 16'd0);
    send_event(MODE_ECHO, 16'd1);
    send_event(MODE_TIMEOUT, 16'hFFFF);
    send_event(MODE_CHECK, 16'd0);
    send_event(MODE_CHECK, 16'd0);
    send_event(MODE_CLEAR, 16'd0);
    send_event(MODE_ECHO, 16'd0);
    send_event(MODE_CHECK, 16'd0);

    // Sensor count of zero acts as one; over limit below the no-obstacle limit
    apply_setting(3'd0, 8'd255, 16'd100, 16'hFFFF);
    send_event(MODE_ECHO, 16'd50);
    send_event(MODE_ECHO, 16'd101);
    send_event(MODE_TIMEOUT, 16'd0);
    send_event(MODE_CHECK, 16'd0);

    // Sensor count above the sensor total acts as the total
    apply_setting(3'd7, 8'd0, 16'd100, 16'hFFFF);
    send_event(MODE_ECHO, 16'hFFFF);
    send_event(MODE_ECHO, 16'd100);
    send_event(MODE_CHECK, 16'd0);

    // Random phases
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    apply_setting(3'd4, 8'd10, 16'd51200, 16'd32000);
    run_random(90, 60, 15, 15, 10);

    // Full-range storage on one sensor while the output stalls for a long time
    send_gaps = 1'b0;
    apply_setting(3'd1, 8'($urandom_range(0, 255)), 16'hFFFF, 16'hFFFF);
    long_hold_req = 1'b1;
    run_random(90, 80, 10, 5, 5);

    send_gaps = 1'b1;
    apply_setting(3'd2, 8'd0, 16'($urandom), 16'($urandom));
    run_random(70, 55, 20, 15, 10);

    apply_setting(3'd3, 8'($urandom_range(1, 5)), 16'($urandom_range(40000, 65535)),
                  16'($urandom_range(0, 40000)));
    run_random(70, 55, 20, 15, 10);

    // Drive one sensor's fault count into saturation
    apply_setting(3'd1, 8'd254, 16'd51200, 16'd32000);
    run_random(280, 0, 90, 8, 2);

    apply_setting(3'($urandom_range(5, 7)), 8'd255, 16'd0, 16'hFFFF);
    run_random(60, 50, 20, 20, 10);

    // Final stretch with no idling on either side
    apply_setting(3'd4, 8'd3, 16'd60000, 16'd50000);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_random(80, 60, 15, 15, 10);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
